### rtl/swap_slot_run_allocator_defines.svh
// Assertion macros shared by the swap slot run allocator.
// Included by the top level; needs nothing else.
`ifndef SWAP_SLOT_RUN_ALLOCATOR_DEFINES_SVH
`define SWAP_SLOT_RUN_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define SSRA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ssra_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the swap slot run allocator.
// No dependencies.
package ssra_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_IDX_W = 5;
   localparam int SLOT_W    = 15;

   typedef enum logic [3:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_LOAD,
      OP_DISPATCH,
      OP_READ,
      OP_SCAN,
      OP_FREE_MARK,
      OP_WRITE,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic out_of_range;
      logic no_run;
      logic scan_hit;
      logic scan_ok;
      logic scan_last;
      logic rmw_last;
      logic clear_last;
   } dp_status_type;

endpackage

### rtl/ssra_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ssra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ssra_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the swap slot run allocator.
// Depends on ssra_pkg; drives the datapath by command and reads its status.
module ssra_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  ssra_pkg::dp_status_type status,
   output ssra_pkg::dp_cmd_type    cmd
);
   import ssra_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_FREE_RD,
      ST_FREE_EV,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = OP_HOLD;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.op = OP_DISPATCH;
            if (status.is_free) begin
               state_in = status.out_of_range ? ST_DONE : ST_FREE_RD;
            end else begin
               state_in = status.no_run ? ST_DONE : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.op   = OP_READ;
            state_in = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            cmd.op = OP_SCAN;
            if (status.scan_hit && status.scan_ok) begin
               state_in = ST_RMW_RD;
            end else if (status.scan_hit || status.scan_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_FREE_RD: begin
            cmd.op   = OP_READ;
            state_in = ST_FREE_EV;
         end
         ST_FREE_EV: begin
            cmd.op   = OP_FREE_MARK;
            state_in = ST_RMW_RD;
         end
         ST_RMW_RD: begin
            cmd.op   = OP_READ;
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            cmd.op   = OP_WRITE;
            state_in = status.rmw_last ? ST_DONE : ST_RMW_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/ssra_dp.sv
`timescale 1ns / 1ps
// Datapath of the swap slot run allocator: slot bitmap RAM, word scanner,
// run tracker and read-modify-write range update. Depends on ssra_pkg, ssra_ram.
module ssra_dp #(
   parameter int SLOTS    = 32768,
   parameter int HUGE_RUN = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ssra_pkg::dp_cmd_type          cmd,
   input  logic                          req_mode,
   input  logic                          req_huge,
   input  logic [ssra_pkg::SLOT_W-1:0]   req_slot_index,
   output ssra_pkg::dp_status_type       status,
   output logic [ssra_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_status
);
   import ssra_pkg::*;

   localparam int Words    = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AddrW    = $clog2(Words);
   localparam int PosW     = $clog2(Words * WORD_BITS + HUGE_RUN + 1);
   localparam int RunW     = $clog2(HUGE_RUN + WORD_BITS + 1);
   localparam int Lim      = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);
   localparam int LimWords = (Lim + WORD_BITS - 1) / WORD_BITS;
   localparam int SlotsRem = SLOTS % WORD_BITS;
   localparam int LimRem   = Lim % WORD_BITS;
   localparam logic [WORD_BITS-1:0] SlotsTail = (SlotsRem == 0) ? '1 :
      WORD_BITS'((64'(1) << SlotsRem) - 64'(1));
   localparam logic [WORD_BITS-1:0] LimTail = (LimRem == 0) ? '1 :
      WORD_BITS'((64'(1) << LimRem) - 64'(1));
   localparam bit NoRun       = (HUGE_RUN > SLOTS);
   localparam bit RunFitsWord = (HUGE_RUN <= WORD_BITS);
   localparam int WinW        = RunFitsWord ? HUGE_RUN : WORD_BITS;
   localparam logic [WORD_BITS-1:0] WinMask = WORD_BITS'((64'(1) << WinW) - 64'(1));

   logic [AddrW-1:0]  ptr_ff, ptr_in;
   logic [RunW-1:0]   run_ff, run_in;
   logic [PosW-1:0]   lo_ff, lo_in;
   logic [PosW-1:0]   last_ff, last_in;
   logic [PosW-1:0]   idx_ff, idx_in;
   logic              free_ff, free_in;
   logic              huge_ff, huge_in;
   logic              oob_ff, oob_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              res_fail_ff, res_fail_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_fail_ff, rsp_fail_in;

   logic                   wr_en, rd_en;
   logic [2*WORD_BITS-1:0] wr_data, rd_data;
   logic [WORD_BITS-1:0]   taken, mark;

   logic [AddrW-1:0]     scan_last_word;
   logic                 at_last;
   logic [WORD_BITS-1:0] vmask, fvec;
   logic                 s_hit;
   logic [BIT_IDX_W-1:0] s_bit;
   logic [BIT_IDX_W:0]   trail, lead;
   logic                 all_free;
   logic [RunW-1:0]      need, run_next;
   logic                 pre_hit, int_hit, r_hit;
   logic [BIT_IDX_W-1:0] end_pre, int_bit, r_bit;
   logic [PosW-1:0]      end_pos, start_huge, start_single, start;
   logic                 hit, start_ok;
   logic [PosW-1:0]      idx_pos, free_sum, free_last;
   logic                 mark_bit;
   logic [AddrW-1:0]     lo_word, last_word;
   logic [BIT_IDX_W-1:0] lo_b, hi_b;
   logic [WORD_BITS-1:0] rmw_mask, start_bit, new_taken, new_mark;

   ssra_ram #(
      .WIDTH(2 * WORD_BITS),
      .DEPTH(Words)
   ) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(ptr_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(ptr_ff),
      .rd_data(rd_data)
   );

   assign taken = rd_data[WORD_BITS-1:0];
   assign mark  = rd_data[2*WORD_BITS-1:WORD_BITS];

   // word scan
   always_comb begin
      scan_last_word = huge_ff ? AddrW'(Words - 1) : AddrW'(LimWords - 1);
      at_last        = (ptr_ff == scan_last_word);
      vmask          = at_last ? (huge_ff ? SlotsTail : LimTail) : '1;
      fvec           = ~taken & vmask;
      all_free       = (fvec == '1);

      s_hit = 1'b0;
      s_bit = '0;
      trail = (BIT_IDX_W + 1)'(WORD_BITS);
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (fvec[b]) begin
            s_hit = 1'b1;
            s_bit = BIT_IDX_W'(b);
         end else begin
            trail = (BIT_IDX_W + 1)'(b);
         end
      end
      lead = (BIT_IDX_W + 1)'(WORD_BITS);
      for (int b = 0; b < WORD_BITS; b++) begin
         if (!fvec[b]) begin
            lead = (BIT_IDX_W + 1)'(WORD_BITS - 1 - b);
         end
      end

      need    = RunW'(HUGE_RUN) - run_ff;
      pre_hit = (need <= RunW'(trail));
      end_pre = BIT_IDX_W'(need - RunW'(1));

      int_hit = 1'b0;
      int_bit = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (RunFitsWord && (j >= WinW - 1)) begin
            if (((fvec >> (j + 1 - WinW)) & WinMask) == WinMask) begin
               int_hit = 1'b1;
               int_bit = BIT_IDX_W'(j);
            end
         end
      end

      r_hit = pre_hit || int_hit;
      r_bit = (pre_hit && (!int_hit || (end_pre <= int_bit))) ? end_pre : int_bit;
      run_next = all_free ? (run_ff + RunW'(WORD_BITS)) : RunW'(lead);

      end_pos      = PosW'({ptr_ff, r_bit});
      start_huge   = end_pos - PosW'(HUGE_RUN - 1);
      start_single = PosW'({ptr_ff, s_bit});
      hit          = huge_ff ? r_hit : s_hit;
      start        = huge_ff ? start_huge : start_single;
      start_ok     = (32'(start) < 32'(Lim));
   end

   // free decode and range update
   always_comb begin
      idx_pos   = PosW'(req_slot_index);
      mark_bit  = mark[idx_ff[BIT_IDX_W-1:0]];
      free_sum  = idx_ff + PosW'(HUGE_RUN - 1);
      free_last = !mark_bit ? idx_ff :
                  ((free_sum > PosW'(SLOTS - 1)) ? PosW'(SLOTS - 1) : free_sum);

      lo_word   = lo_ff[AddrW+BIT_IDX_W-1:BIT_IDX_W];
      last_word = last_ff[AddrW+BIT_IDX_W-1:BIT_IDX_W];
      lo_b      = (ptr_ff == lo_word) ? lo_ff[BIT_IDX_W-1:0] : '0;
      hi_b      = (ptr_ff == last_word) ? last_ff[BIT_IDX_W-1:0] : '1;
      for (int b = 0; b < WORD_BITS; b++) begin
         rmw_mask[b] = (BIT_IDX_W'(b) >= lo_b) && (BIT_IDX_W'(b) <= hi_b);
      end
      start_bit = (ptr_ff == lo_word) ? (WORD_BITS'(1) << lo_ff[BIT_IDX_W-1:0]) : '0;
      new_taken = free_ff ? (taken & ~rmw_mask) : (taken | rmw_mask);
      new_mark  = (!free_ff && huge_ff) ? (mark | start_bit) : (mark & ~rmw_mask);
   end

   always_comb begin
      ptr_in      = ptr_ff;
      run_in      = run_ff;
      lo_in       = lo_ff;
      last_in     = last_ff;
      idx_in      = idx_ff;
      free_in     = free_ff;
      huge_in     = huge_ff;
      oob_in      = oob_ff;
      res_slot_in = res_slot_ff;
      res_fail_in = res_fail_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_fail_in = rsp_fail_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      wr_data     = {new_mark, new_taken};
      unique case (cmd.op)
         OP_HOLD: begin
         end
         OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            ptr_in  = (ptr_ff == AddrW'(Words - 1)) ? '0 : ptr_ff + AddrW'(1);
         end
         OP_LOAD: begin
            free_in     = req_mode;
            huge_in     = req_huge;
            idx_in      = idx_pos;
            oob_in      = (32'(req_slot_index) >= 32'(SLOTS));
            ptr_in      = req_mode ? idx_pos[AddrW+BIT_IDX_W-1:BIT_IDX_W] : '0;
            run_in      = '0;
            res_slot_in = '0;
            res_fail_in = 1'b0;
         end
         OP_DISPATCH: begin
            res_fail_in = !free_ff && huge_ff && NoRun;
         end
         OP_READ: begin
            rd_en = 1'b1;
         end
         OP_SCAN: begin
            if (hit) begin
               if (start_ok) begin
                  lo_in       = start;
                  last_in     = huge_ff ? end_pos : start;
                  ptr_in      = start[AddrW+BIT_IDX_W-1:BIT_IDX_W];
                  res_slot_in = SLOT_W'(start);
               end else begin
                  res_fail_in = 1'b1;
               end
            end else if (at_last) begin
               res_fail_in = 1'b1;
            end else begin
               ptr_in = ptr_ff + AddrW'(1);
               run_in = run_next;
            end
         end
         OP_FREE_MARK: begin
            lo_in   = idx_ff;
            last_in = free_last;
         end
         OP_WRITE: begin
            wr_en = 1'b1;
            if (ptr_ff != last_word) begin
               ptr_in = ptr_ff + AddrW'(1);
            end
         end
         OP_EMIT: begin
            rsp_slot_in = res_slot_ff;
            rsp_fail_in = res_fail_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
      run_ff      <= run_in;
      lo_ff       <= lo_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      free_ff     <= free_in;
      huge_ff     <= huge_in;
      oob_ff      <= oob_in;
      res_slot_ff <= res_slot_in;
      res_fail_ff <= res_fail_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_fail_ff <= rsp_fail_in;
   end

   assign status.is_free      = free_ff;
   assign status.out_of_range = oob_ff;
   assign status.no_run       = huge_ff && NoRun;
   assign status.scan_hit     = hit;
   assign status.scan_ok      = start_ok;
   assign status.scan_last    = at_last;
   assign status.rmw_last     = (ptr_ff == last_word);
   assign status.clear_last   = (ptr_ff == AddrW'(Words - 1));

   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_fail_ff;

endmodule

### rtl/swap_slot_run_allocator.sv
`timescale 1ns / 1ps
// Swap slot run allocator. A request allocates the lowest free slot, or
// the lowest fully free run of HUGE_RUN slots inside the store, or frees a
// slot or a whole run by the start mark kept per slot; the response gives
// the first slot and a failure status. The bitmap lives in a RAM of 32-slot
// words (taken bits and start marks side by side) and is swept word by word:
// a scan reads and then evaluates each word visited, and the marking or
// clearing pass reads and then writes each word the range touches; accept,
// dispatch and response are steps of their own. A free first reads and
// decodes the start mark of its slot; a free beyond the store goes straight
// to the response. After reset a clearing pass writes every word of the RAM
// before the first request is taken. Requests are handled one at a time;
// the response is registered and held until taken, while the next request
// may already enter.
// Depends on ssra_pkg, ssra_ctrl, ssra_dp, ssra_ram and the defines header.
`include "swap_slot_run_allocator_defines.svh"
module swap_slot_run_allocator #(
   parameter int SLOTS    = 32768,
   parameter int HUGE_RUN = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [14:0] slot_index, [15] zero
   input  logic [1:0]  req_tuser,  // [0] mode, [1] huge
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [14:0] slot, [15] zero
   output logic [0:0]  rsp_tuser   // [0] status
);
   import ssra_pkg::*;

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [SLOT_W-1:0] rsp_slot;
   logic              rsp_status;

   ssra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ssra_dp #(
      .SLOTS   (SLOTS),
      .HUGE_RUN(HUGE_RUN)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_mode      (req_tuser[0]),
      .req_huge      (req_tuser[1]),
      .req_slot_index(req_tdata[SLOT_W-1:0]),
      .status        (status),
      .rsp_slot      (rsp_slot),
      .rsp_status    (rsp_status)
   );

   assign rsp_tdata = {1'b0, rsp_slot};
   assign rsp_tuser = rsp_status;

   `SSRA_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_tready,
      "request taken during clear")
   `SSRA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready,
      "second request taken while busy")
   `SSRA_ASSERT_NOW(a_fail_slot_zero, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tdata[14:0] == 15'd0, "failed response with nonzero slot")

endmodule
